@@ sv/ctp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// ctp_pkg: shared types and constants for the cell text to position unit
// Holds the parser phase encoding, character codes, limits and the structs
// passed between the top level and the parse stage.
// -----------------------------------------------------------------------------
package ctp_pkg;

	// Largest one-based row and column that still give a valid position.
	localparam int ROW_LIMIT = 16384;
	localparam int COL_LIMIT = 16384;

	// Zero-based index width on the result side.
	localparam int IDX_W = 14;

	// Stored accumulator widths: they hold values up to the limit.
	localparam int ROW_W = $clog2(ROW_LIMIT + 1);
	localparam int COL_W = $clog2(COL_LIMIT + 1);

	// Widths of one multiply-accumulate step before the limit check.
	localparam int ROW_WIDE_W = $clog2(ROW_LIMIT * 10 + 10);
	localparam int COL_WIDE_W = $clog2(COL_LIMIT * 26 + 27);

	// ASCII codes that bound the letter and digit ranges.
	localparam logic [7:0] CHAR_A = 8'h41;
	localparam logic [7:0] CHAR_Z = 8'h5A;
	localparam logic [7:0] CHAR_0 = 8'h30;
	localparam logic [7:0] CHAR_9 = 8'h39;

	// Parser phase.
	typedef enum logic [1:0] {
		PH_START,
		PH_LETTERS,
		PH_DIGITS,
		PH_ERROR
	} ctp_phase_t;

	// One character of a reference as held in the input register.
	typedef struct packed {
		logic [7:0] char_code;
		logic       is_last;
	} ctp_char_t;

	// One result item.
	typedef struct packed {
		logic             valid_res;
		logic [IDX_W-1:0] row_index;
		logic [IDX_W-1:0] col_index;
	} ctp_result_t;

endpackage : ctp_pkg
`default_nettype wire

@@ sv/ctp_parse.sv @@
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// ctp_parse: per-character parse stage
// Keeps the phase and the row and column accumulators, advances them by one
// character when told to, and forms the result for the last character.
// -----------------------------------------------------------------------------
module ctp_parse
	import ctp_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        take,
	input  wire ctp_char_t   in_char,
	output ctp_result_t      res
);

	ctp_phase_t       phase_q;
	ctp_phase_t       phase_d;
	logic [ROW_W-1:0] row_q;
	logic [ROW_W-1:0] row_d;
	logic [COL_W-1:0] col_q;
	logic [COL_W-1:0] col_d;

	logic                  is_letter;
	logic                  is_digit;
	logic [7:0]            letter_val;
	logic [7:0]            digit_val;
	logic [COL_WIDE_W-1:0] col_mac;
	logic [ROW_WIDE_W-1:0] row_mac;

	// Character class and the value each class contributes.
	always_comb begin
		is_letter  = (in_char.char_code >= CHAR_A) && (in_char.char_code <= CHAR_Z);
		is_digit   = (in_char.char_code >= CHAR_0) && (in_char.char_code <= CHAR_9);
		letter_val = in_char.char_code - CHAR_A + 8'd1;
		digit_val  = in_char.char_code - CHAR_0;
		col_mac    = COL_WIDE_W'(col_q) * COL_WIDE_W'(26) + COL_WIDE_W'(letter_val[4:0]);
		row_mac    = ROW_WIDE_W'(row_q) * ROW_WIDE_W'(10) + ROW_WIDE_W'(digit_val[3:0]);
	end

	// Next phase and accumulators after this character.
	always_comb begin
		phase_d = phase_q;
		row_d   = row_q;
		col_d   = col_q;
		if (phase_q != PH_ERROR) begin
			if (is_letter) begin
				if (phase_q == PH_DIGITS) begin
					phase_d = PH_ERROR;
				end else if (col_mac > COL_WIDE_W'(COL_LIMIT)) begin
					phase_d = PH_ERROR;
				end else begin
					phase_d = PH_LETTERS;
					col_d   = col_mac[COL_W-1:0];
				end
			end else if (is_digit) begin
				case (phase_q)
					PH_LETTERS: begin
						if (digit_val[3:0] == 4'd0) begin
							phase_d = PH_ERROR;
						end else begin
							phase_d = PH_DIGITS;
							row_d   = ROW_W'(digit_val[3:0]);
						end
					end
					PH_DIGITS: begin
						if (row_mac > ROW_WIDE_W'(ROW_LIMIT)) begin
							phase_d = PH_ERROR;
						end else begin
							row_d = row_mac[ROW_W-1:0];
						end
					end
					default: begin
						phase_d = PH_ERROR;
					end
				endcase
			end else begin
				phase_d = PH_ERROR;
			end
		end
	end

	// Result for a last character; the digits phase implies both numbers are in range.
	always_comb begin
		res.valid_res = (phase_d == PH_DIGITS);
		res.row_index = '0;
		res.col_index = '0;
		if (phase_d == PH_DIGITS) begin
			res.row_index = IDX_W'(row_d - ROW_W'(1));
			res.col_index = IDX_W'(col_d - COL_W'(1));
		end
	end

	// State registers; a last character returns them to the start values.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_START;
			row_q   <= '0;
			col_q   <= '0;
		end else if (take) begin
			if (in_char.is_last) begin
				phase_q <= PH_START;
				row_q   <= '0;
				col_q   <= '0;
			end else begin
				phase_q <= phase_d;
				row_q   <= row_d;
				col_q   <= col_d;
			end
		end
	end

endmodule : ctp_parse
`default_nettype wire

@@ sv/cell_text_to_position_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// cell_text_to_position_unit: A1 cell reference to zero-based row and column
// Usage:
//   The slave stream carries one ASCII character per transaction in s_tdata;
//   s_tlast marks the final character of a reference. Letters give the column
//   in bijective base 26, then digits with no leading zero give the row.
//   For every character with s_tlast set, one transaction leaves on the master
//   stream: m_tuser is the valid flag, m_tdata holds row and column indices.
//   A malformed or out-of-range reference gives m_tuser 0 with zero indices.
// Timing:
//   A character accepted at one clock edge is held in the input register and
//   parsed there; a last character's result enters the result register, and
//   sets m_tvalid, once that register is free. One character is accepted
//   every cycle unless a last character waits behind a held result; the
//   multiply-accumulates and limit compares lie before the result register.
// Reset and stall:
//   Reset empties both registers and returns the parser to its start phase.
//   While m_tready is low and a result waits, characters that are not last
//   keep flowing; a last character waits in the input register and s_tready
//   drops until the pending result is taken.
// -----------------------------------------------------------------------------
module cell_text_to_position_unit
	import ctp_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Slave stream.
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] char_code
	input  wire logic        s_tlast,   // is_last
	// Master stream.
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,   // [13:0] row_index, [27:14] col_index, [31:28] zero
	output logic             m_tuser    // [0] valid_res
);

	logic        valid_s1;
	ctp_char_t   char_s1;
	logic        take;
	logic        out_free;
	ctp_result_t res;
	logic        m_valid_q;
	ctp_result_t res_q;

	// Handshake between input register, parse stage and result register.
	always_comb begin
		out_free = !m_valid_q || m_tready;
		take     = valid_s1 && (!char_s1.is_last || out_free);
		s_tready = !valid_s1 || take;
	end

	// Input register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// Input register payload.
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			char_s1.char_code <= s_tdata;
			char_s1.is_last   <= s_tlast;
		end
	end

	ctp_parse u_parse (
		.clk     (clk),
		.arst_n  (arst_n),
		.take    (take),
		.in_char (char_s1),
		.res     (res)
	);

	// Result register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (take && char_s1.is_last) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (take && char_s1.is_last) begin
			res_q <= res;
		end
	end

	// Master stream outputs.
	always_comb begin
		m_tvalid = m_valid_q;
		m_tuser  = res_q.valid_res;
		m_tdata  = {4'b0000, res_q.col_index, res_q.row_index};
	end

	// An invalid result carries zero indices.
	a_invalid_zero : assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata == 32'd0)
		else $error("invalid result with nonzero indices");

	// A new result only follows a last character taken from the input register.
	a_result_source : assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(valid_s1 && char_s1.is_last))
		else $error("result appeared without a last character");

	// The slave side stalls only when a last character waits behind a held result.
	a_stall_cause : assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> valid_s1 && char_s1.is_last && m_tvalid && !m_tready)
		else $error("slave stalled without a pending result");

	// A held result stays put while the master side stalls.
	a_hold_result : assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("held result changed during stall");

endmodule : cell_text_to_position_unit
`default_nettype wire
